@@ rtl/core/wlsdc_pkg.sv @@
// Shared types, constants and tables for the winch line stop and drum current block.
package wlsdc_pkg;

    localparam int KIND_W   = 2;
    localparam int DIST_W   = 32;
    localparam int TIME_W   = 32;
    localparam int STATE_W  = 3;
    localparam int LINE_W   = 31;
    localparam int AMPS_W   = 8;
    localparam int THR_W    = 16;
    localparam int CUR_W    = 8;
    localparam int DIAM_W   = 9;
    localparam int CNT_W    = 2;
    localparam int NUM_AMPS = 6;

    localparam int ADDR_W   = 5;
    localparam int APB_DW   = 32;
    localparam int REG_IDX_W = 3;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 56;

    localparam logic [KIND_W-1:0] KIND_ODO   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CMD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PRESS = 2'd2;

    localparam logic [STATE_W-1:0] STATE_OFF = 3'd0;
    localparam logic [STATE_W-1:0] STATE_MAX = 3'd6;

    localparam logic [TIME_W-1:0] PRESS_WINDOW = 32'd500;
    localparam logic [CNT_W-1:0]  PRESS_FIRST  = 2'd1;
    localparam logic [CNT_W-1:0]  PRESS_DOUBLE = 2'd2;
    localparam logic [CNT_W-1:0]  PRESS_SAT    = 2'd3;

    localparam logic [LINE_W-1:0] LINE_MAX = '1;

    localparam logic [REG_IDX_W-1:0] REG_AMPS_ONE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_AMPS_TWO   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_AMPS_THREE = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_AMPS_FOUR  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_AMPS_FIVE  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_AMPS_SIX   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ARM_THR    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_STOP_THR   = 3'd7;

    localparam logic [NUM_AMPS-1:0][AMPS_W-1:0] AMPS_RST =
        {8'd140, 8'd120, 8'd100, 8'd60, 8'd40, 8'd20};
    localparam logic [THR_W-1:0] ARM_RST  = 16'd40;
    localparam logic [THR_W-1:0] STOP_RST = 16'd35;

    // drum model: sq = CORE_SQ + floor(rem * 1909 * 2^14 / 15), rem = 1500 - min(line, 1500)
    localparam int REM_W = 11;
    localparam logic [REM_W-1:0] TOTAL_LINE = 11'd1500;
    localparam int SPAN_W = 22;
    localparam logic [REM_W-1:0] SPAN_MUL = 11'd1909;
    localparam int RECIP15_W  = 23;
    localparam logic [RECIP15_W-1:0] RECIP15 = 23'd4473925;
    localparam int RECIP15_SH = 26;
    localparam int Q_W        = 18;
    localparam int FRAC_SH    = 14;
    localparam int FRAC_W     = 15;
    localparam int FRAC_IDX_W = 4;

    localparam int SQ_W       = 33;
    localparam int ROOT_W     = 17;
    localparam int ROOT_CNT_W = 5;
    localparam logic [SQ_W-1:0] CORE_SQ = 33'd1474560000;

    localparam logic [FRAC_W-1:0] SQ_FRAC [16] = '{
        15'd0,     15'd1092,  15'd2184,  15'd3276,
        15'd4369,  15'd5461,  15'd6553,  15'd7645,
        15'd8738,  15'd9830,  15'd10922, 15'd12014,
        15'd13107, 15'd14199, 15'd15291, 15'd16384
    };

    // current = floor((amps * d8 >> 8) / 265), capped
    localparam int PROD_W      = AMPS_W + ROOT_W;
    localparam int SCALE_IN_W  = 17;
    localparam int RECIP265_W  = 17;
    localparam logic [RECIP265_W-1:0] RECIP265 = 17'd126621;
    localparam int RECIP265_SH = 25;
    localparam int SCALE_W     = 9;
    localparam logic [SCALE_W-1:0] CUR_CAP = 9'd200;

    typedef struct packed {
        logic [NUM_AMPS-1:0][AMPS_W-1:0] amps;
        logic [THR_W-1:0]                arm_thr;
        logic [THR_W-1:0]                stop_thr;
    } cfg_t;

    typedef struct packed {
        logic event_en;
        logic line_en;
        logic flag_en;
    } ctrl_t;

    typedef struct packed {
        logic [LINE_W-1:0]  line;
        logic               armed;
        logic               tripped;
        logic [STATE_W-1:0] drive_state;
    } stat_t;

    function automatic logic [AMPS_W-1:0] amps_for(input cfg_t cfg,
                                                   input logic [STATE_W-1:0] st);
        logic [STATE_W-1:0] idx;
        idx = st - 3'd1;
        if (st == STATE_OFF || st > STATE_MAX) begin
            return '0;
        end
        return cfg.amps[idx];
    endfunction

endpackage

@@ rtl/core/wlsdc_cfg.sv @@
// Configuration register file behind the APB-style port.
module wlsdc_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wlsdc_pkg::ADDR_W-1:0]  paddr,
    input  logic [wlsdc_pkg::APB_DW-1:0]  pwdata,
    output logic [wlsdc_pkg::APB_DW-1:0]  prdata,
    output wlsdc_pkg::cfg_t               cfg
);

    wlsdc_pkg::cfg_t cfg_reg, cfg_next;
    logic [wlsdc_pkg::REG_IDX_W-1:0] idx;
    logic wr_en;

    assign idx   = paddr[wlsdc_pkg::ADDR_W-1:2];
    assign wr_en = psel & penable & pwrite;
    assign cfg   = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                wlsdc_pkg::REG_AMPS_ONE:   cfg_next.amps[0] = pwdata[7:0];
                wlsdc_pkg::REG_AMPS_TWO:   cfg_next.amps[1] = pwdata[7:0];
                wlsdc_pkg::REG_AMPS_THREE: cfg_next.amps[2] = pwdata[7:0];
                wlsdc_pkg::REG_AMPS_FOUR:  cfg_next.amps[3] = pwdata[7:0];
                wlsdc_pkg::REG_AMPS_FIVE:  cfg_next.amps[4] = pwdata[7:0];
                wlsdc_pkg::REG_AMPS_SIX:   cfg_next.amps[5] = pwdata[7:0];
                wlsdc_pkg::REG_ARM_THR:    cfg_next.arm_thr = pwdata[15:0];
                wlsdc_pkg::REG_STOP_THR:   cfg_next.stop_thr = pwdata[15:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            wlsdc_pkg::REG_AMPS_ONE:   prdata = 32'(cfg_reg.amps[0]);
            wlsdc_pkg::REG_AMPS_TWO:   prdata = 32'(cfg_reg.amps[1]);
            wlsdc_pkg::REG_AMPS_THREE: prdata = 32'(cfg_reg.amps[2]);
            wlsdc_pkg::REG_AMPS_FOUR:  prdata = 32'(cfg_reg.amps[3]);
            wlsdc_pkg::REG_AMPS_FIVE:  prdata = 32'(cfg_reg.amps[4]);
            wlsdc_pkg::REG_AMPS_SIX:   prdata = 32'(cfg_reg.amps[5]);
            wlsdc_pkg::REG_ARM_THR:    prdata = 32'(cfg_reg.arm_thr);
            wlsdc_pkg::REG_STOP_THR:   prdata = 32'(cfg_reg.stop_thr);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.amps     <= wlsdc_pkg::AMPS_RST;
            cfg_reg.arm_thr  <= wlsdc_pkg::ARM_RST;
            cfg_reg.stop_thr <= wlsdc_pkg::STOP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/core/wlsdc_ctrl.sv @@
// Event handling, line out and line stop flags.
module wlsdc_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  wlsdc_pkg::ctrl_t                    ctrl,
    input  wlsdc_pkg::cfg_t                     cfg,
    input  logic [wlsdc_pkg::KIND_W-1:0]        kind,
    input  logic signed [wlsdc_pkg::DIST_W-1:0] distance,
    input  logic [wlsdc_pkg::STATE_W-1:0]       command_state,
    input  logic [wlsdc_pkg::TIME_W-1:0]        time_ms,
    output wlsdc_pkg::stat_t                    stat
);

    logic signed [wlsdc_pkg::DIST_W-1:0] offset_reg, offset_next;
    logic signed [wlsdc_pkg::DIST_W-1:0] dist_reg, dist_next;
    logic                                armed_reg, armed_next;
    logic                                tripped_reg, tripped_next;
    logic [wlsdc_pkg::STATE_W-1:0]       state_reg, state_next;
    logic [wlsdc_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [wlsdc_pkg::TIME_W-1:0]        ptime_reg, ptime_next;
    logic [wlsdc_pkg::LINE_W-1:0]        line_reg, line_next;

    logic [wlsdc_pkg::TIME_W-1:0] dt;
    logic [wlsdc_pkg::CNT_W-1:0]  press_cnt;
    logic [wlsdc_pkg::DIST_W:0]   diff;
    logic                         arm_hit;
    logic                         stop_hit;

    assign dt = time_ms - ptime_reg;

    always_comb begin
        if (dt < wlsdc_pkg::PRESS_WINDOW) begin
            press_cnt = (cnt_reg == wlsdc_pkg::PRESS_SAT) ? cnt_reg : cnt_reg + 2'd1;
        end else begin
            press_cnt = wlsdc_pkg::PRESS_FIRST;
        end
    end

    assign diff = {offset_reg[wlsdc_pkg::DIST_W-1], offset_reg}
                - {dist_reg[wlsdc_pkg::DIST_W-1], dist_reg};

    always_comb begin
        if (diff[wlsdc_pkg::DIST_W]) begin
            line_next = '0;
        end else if (diff[wlsdc_pkg::DIST_W-1]) begin
            line_next = wlsdc_pkg::LINE_MAX;
        end else begin
            line_next = diff[wlsdc_pkg::LINE_W-1:0];
        end
        if (!ctrl.line_en) begin
            line_next = line_reg;
        end
    end

    assign arm_hit  = line_reg > wlsdc_pkg::LINE_W'(cfg.arm_thr);
    assign stop_hit = line_reg < wlsdc_pkg::LINE_W'(cfg.stop_thr);

    always_comb begin
        offset_next  = offset_reg;
        dist_next    = dist_reg;
        armed_next   = armed_reg;
        tripped_next = tripped_reg;
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ptime_next   = ptime_reg;
        if (ctrl.event_en) begin
            unique case (kind)
                wlsdc_pkg::KIND_ODO: begin
                    dist_next = distance;
                end
                wlsdc_pkg::KIND_CMD: begin
                    if (!tripped_reg && command_state <= wlsdc_pkg::STATE_MAX) begin
                        state_next = command_state;
                    end
                end
                wlsdc_pkg::KIND_PRESS: begin
                    cnt_next   = press_cnt;
                    ptime_next = time_ms;
                    if (press_cnt == wlsdc_pkg::PRESS_DOUBLE) begin
                        armed_next   = 1'b0;
                        tripped_next = 1'b0;
                    end else begin
                        offset_next = dist_reg;
                    end
                end
                default: begin
                end
            endcase
        end else if (ctrl.flag_en) begin
            // arm first, then trip on the same line value
            armed_next   = armed_reg | arm_hit;
            tripped_next = tripped_reg | (armed_next & stop_hit);
            if (tripped_next || state_reg > wlsdc_pkg::STATE_MAX) begin
                state_next = wlsdc_pkg::STATE_OFF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg  <= '0;
            dist_reg    <= '0;
            armed_reg   <= 1'b0;
            tripped_reg <= 1'b0;
            state_reg   <= wlsdc_pkg::STATE_OFF;
            cnt_reg     <= '0;
            ptime_reg   <= '0;
            line_reg    <= '0;
        end else begin
            offset_reg  <= offset_next;
            dist_reg    <= dist_next;
            armed_reg   <= armed_next;
            tripped_reg <= tripped_next;
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ptime_reg   <= ptime_next;
            line_reg    <= line_next;
        end
    end

    assign stat.line        = line_reg;
    assign stat.armed       = armed_reg;
    assign stat.tripped     = tripped_reg;
    assign stat.drive_state = state_reg;

endmodule

@@ rtl/core/wlsdc_isqrt.sv @@
// Digit-serial integer square root, two radicand bits per cycle.
module wlsdc_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [wlsdc_pkg::SQ_W-1:0]    radicand,
    output logic                          done,
    output logic [wlsdc_pkg::ROOT_W-1:0]  root
);

    localparam int X_W     = 2 * wlsdc_pkg::ROOT_W;
    localparam int REM_W   = wlsdc_pkg::ROOT_W + 1;
    localparam int TRIAL_W = REM_W + 2;

    logic [X_W-1:0]                      x_reg, x_next;
    logic [REM_W-1:0]                    rem_reg, rem_next;
    logic [wlsdc_pkg::ROOT_W-1:0]        root_reg, root_next;
    logic [wlsdc_pkg::ROOT_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                                done_reg, done_next;

    logic [TRIAL_W-1:0] trial;
    logic [TRIAL_W-1:0] test;
    logic [TRIAL_W-1:0] diff;
    logic               ge;

    assign trial = {rem_reg, x_reg[X_W-1 -: 2]};
    assign test  = TRIAL_W'({root_reg, 2'b01});
    assign ge    = trial >= test;
    assign diff  = trial - test;

    always_comb begin
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = X_W'(radicand);
            rem_next  = '0;
            root_next = '0;
            cnt_next  = wlsdc_pkg::ROOT_CNT_W'(wlsdc_pkg::ROOT_W);
        end else if (cnt_reg != '0) begin
            x_next    = {x_reg[X_W-3:0], 2'b00};
            rem_next  = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            root_next = {root_reg[wlsdc_pkg::ROOT_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == wlsdc_pkg::ROOT_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ rtl/core/winch_line_stop_and_drum_current_top.sv @@
// Top level: request sequencer, drum model arithmetic and result register.
// Each request (odometer sample, drive-state command or button press) yields one result
// after the line, flag, span, reciprocal, square root, product and scaling steps; the
// bit-serial square root retires one root bit per cycle. Requests are taken one at a
// time; the next can be taken from the cycle in which the last result enters the output
// register, which holds it, so a new request can enter while the last result waits.
module winch_line_stop_and_drum_current_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // distance[31:0], command_state[34:32], time_ms[66:35], zero fill
    input  logic [wlsdc_pkg::S_DATA_W-1:0]    s_tdata,
    // kind[1:0]
    input  logic [wlsdc_pkg::KIND_W-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // line_out[30:0], armed[31], stopped[32], drive_state[35:33],
    // drive_current[43:36], drum_diameter[52:44], zero fill
    output logic [wlsdc_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wlsdc_pkg::ADDR_W-1:0]      paddr,
    input  logic [wlsdc_pkg::APB_DW-1:0]      pwdata,
    output logic [wlsdc_pkg::APB_DW-1:0]      prdata,
    output logic                              pready
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LINE  = 4'd1;
    localparam logic [3:0] ST_FLAG  = 4'd2;
    localparam logic [3:0] ST_SPAN  = 4'd3;
    localparam logic [3:0] ST_RECIP = 4'd4;
    localparam logic [3:0] ST_SQ    = 4'd5;
    localparam logic [3:0] ST_ROOT  = 4'd6;
    localparam logic [3:0] ST_PROD  = 4'd7;
    localparam logic [3:0] ST_SCALE = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    localparam int RMUL_W = wlsdc_pkg::SPAN_W + wlsdc_pkg::RECIP15_W;
    localparam int SMUL_W = wlsdc_pkg::SCALE_IN_W + wlsdc_pkg::RECIP265_W;

    logic [3:0] st_reg, st_next;

    wlsdc_pkg::cfg_t  cfg;
    wlsdc_pkg::ctrl_t ctrl;
    wlsdc_pkg::stat_t stat;

    logic [wlsdc_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [wlsdc_pkg::SPAN_W-1:0]   span_reg, span_next;
    logic [wlsdc_pkg::Q_W-1:0]      q_reg, q_next;
    logic [wlsdc_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [wlsdc_pkg::SCALE_W-1:0]  scale_reg, scale_next;
    logic                           out_valid_reg, out_valid_next;
    logic [wlsdc_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;

    logic [wlsdc_pkg::REM_W-1:0]      line_clip;
    logic [RMUL_W-1:0]                recip_prod;
    logic [wlsdc_pkg::SPAN_W-1:0]     fifteen_q;
    logic [wlsdc_pkg::SPAN_W-1:0]     resid;
    logic [wlsdc_pkg::SQ_W-1:0]       radicand;
    logic                             sq_start;
    logic                             sq_done;
    logic [wlsdc_pkg::ROOT_W-1:0]     root;
    logic [SMUL_W-1:0]                scale_prod;
    logic [wlsdc_pkg::CUR_W-1:0]      drive_current;
    logic                             out_free;
    logic                             accept;

    assign pready   = 1'b1;
    assign accept   = s_tvalid & s_tready;
    assign s_tready = (st_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    assign ctrl.event_en = accept;
    assign ctrl.line_en  = (st_reg == ST_LINE);
    assign ctrl.flag_en  = (st_reg == ST_FLAG);

    wlsdc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    wlsdc_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .cfg           (cfg),
        .kind          (s_tuser),
        .distance      (s_tdata[31:0]),
        .command_state (s_tdata[34:32]),
        .time_ms       (s_tdata[66:35]),
        .stat          (stat)
    );

    wlsdc_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (radicand),
        .done     (sq_done),
        .root     (root)
    );

    assign line_clip = (stat.line > wlsdc_pkg::LINE_W'(wlsdc_pkg::TOTAL_LINE))
                     ? wlsdc_pkg::TOTAL_LINE : stat.line[wlsdc_pkg::REM_W-1:0];

    assign recip_prod = RMUL_W'(span_reg) * RMUL_W'(wlsdc_pkg::RECIP15);
    assign fifteen_q  = wlsdc_pkg::SPAN_W'({q_reg, 4'b0000}) - wlsdc_pkg::SPAN_W'(q_reg);
    assign resid      = span_reg - fifteen_q;
    assign radicand   = wlsdc_pkg::CORE_SQ
                      + (wlsdc_pkg::SQ_W'(q_reg) << wlsdc_pkg::FRAC_SH)
                      + wlsdc_pkg::SQ_W'(wlsdc_pkg::SQ_FRAC[resid[wlsdc_pkg::FRAC_IDX_W-1:0]]);
    assign sq_start   = (st_reg == ST_SQ);

    assign scale_prod = SMUL_W'(prod_reg[wlsdc_pkg::PROD_W-1:8])
                      * SMUL_W'(wlsdc_pkg::RECIP265);

    assign drive_current = (scale_reg > wlsdc_pkg::CUR_CAP)
                         ? wlsdc_pkg::CUR_CAP[wlsdc_pkg::CUR_W-1:0]
                         : scale_reg[wlsdc_pkg::CUR_W-1:0];

    always_comb begin
        st_next        = st_reg;
        rem_next       = rem_reg;
        span_next      = span_reg;
        q_next         = q_reg;
        prod_next      = prod_reg;
        scale_next     = scale_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (st_reg)
            ST_IDLE: begin
                if (accept) begin
                    st_next = ST_LINE;
                end
            end
            ST_LINE: begin
                st_next = ST_FLAG;
            end
            ST_FLAG: begin
                rem_next = wlsdc_pkg::TOTAL_LINE - line_clip;
                st_next  = ST_SPAN;
            end
            ST_SPAN: begin
                span_next = wlsdc_pkg::SPAN_W'(rem_reg) * wlsdc_pkg::SPAN_W'(wlsdc_pkg::SPAN_MUL);
                st_next   = ST_RECIP;
            end
            ST_RECIP: begin
                q_next  = recip_prod[wlsdc_pkg::RECIP15_SH +: wlsdc_pkg::Q_W];
                st_next = ST_SQ;
            end
            ST_SQ: begin
                st_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (sq_done) begin
                    st_next = ST_PROD;
                end
            end
            ST_PROD: begin
                prod_next = wlsdc_pkg::PROD_W'(wlsdc_pkg::amps_for(cfg, stat.drive_state))
                          * wlsdc_pkg::PROD_W'(root);
                st_next   = ST_SCALE;
            end
            ST_SCALE: begin
                scale_next = scale_prod[wlsdc_pkg::RECIP265_SH +: wlsdc_pkg::SCALE_W];
                st_next    = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000,
                                      root[wlsdc_pkg::ROOT_W-1:8],
                                      drive_current,
                                      stat.drive_state,
                                      stat.tripped,
                                      stat.armed,
                                      stat.line};
                    st_next        = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        span_reg     <= span_next;
        q_reg        <= q_next;
        prod_reg     <= prod_next;
        scale_reg    <= scale_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ rtl/core/wlsdc_checker.sv @@
// Port-level checks for the winch line stop and drum current block, bound to the top level.
module wlsdc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [wlsdc_pkg::M_DATA_W-1:0]    m_tdata
);

    a_one_request_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while previous one still in work");

    a_stopped_forces_state_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> m_tdata[35:33] == 3'd0)
        else $error("tripped result carries nonzero drive state");

    a_diameter_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[52:44] >= 9'd150 && m_tdata[52:44] <= 9'd265)
        else $error("drum diameter out of range");

    a_current_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[43:36] <= 8'd200)
        else $error("drive current above cap");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind winch_line_stop_and_drum_current_top wlsdc_checker u_wlsdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
